// ----- rtl/core/ffha_pkg.sv -----
// Shared types, constants and codes for the first-fit heap allocator.
`default_nettype none

package ffha_pkg;

    localparam int HEAP_CAPACITY_BYTES = 4096;

    localparam logic [31:0] SIG_FREE     = 32'h0000_F460;
    localparam logic [15:0] SIG_BLOCK    = 16'h8AC0;
    localparam logic [15:0] SIG_DATA     = 16'h03E0;
    localparam logic [15:0] SIG_HEAP     = 16'h2820;
    localparam logic [15:0] SIG_LOW_MASK = 16'h001F;
    localparam logic [12:0] HEAP_BYTES_DEFAULT = 13'd4096;

    localparam logic [1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [1:0] FUNC_RELEASE = 2'd1;
    localparam logic [1:0] FUNC_CHECK   = 2'd2;
    localparam logic [1:0] FUNC_FORMAT  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMEM   = 2'd1;
    localparam logic [1:0] ST_CORRUPT = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] request_size;
        logic [11:0] release_offset;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] payload_offset;
        logic [31:0] used_bytes;
    } out_t;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LOAD,
        OP_RD_P,
        OP_RD_P4,
        OP_LATCH_SZ,
        OP_NEXT,
        OP_MARK,
        OP_ZERO,
        OP_SPLIT_SZ,
        OP_SPLIT_SIG,
        OP_SPLIT_REST,
        OP_ALLOC_DONE,
        OP_REL_INIT,
        OP_REL_FREE,
        OP_MERGE_NEXT,
        OP_BW_INIT,
        OP_BW_ADV,
        OP_P_PREV,
        OP_MERGE_PREV,
        OP_CLR,
        OP_FMT0,
        OP_FMT1,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] code;
        logic       fmt_boot;
    } cmd_t;

    typedef struct packed {
        logic sig_ok;
        logic sig_free;
        logic fits;
        logic nx_ok;
        logic zero_more;
        logic split_ok;
        logic p_lt_h;
        logic have_prev;
        logic rel_bad;
        logic clr_last;
    } stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/ffha_ram.sv -----
// Generic single-write, single-read word RAM with registered read data.
`default_nettype none

module ffha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/ffha_dp.sv -----
// Datapath: heap store, walk pointers, counters and result register.
`default_nettype none

module ffha_dp #(
    parameter int HEAP_CAPACITY_BYTES = ffha_pkg::HEAP_CAPACITY_BYTES
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  ffha_pkg::in_t       in_data,
    input  wire logic           cfg_we,
    input  wire logic [12:0]    cfg_wdata,
    input  ffha_pkg::cmd_t      cmd,
    output ffha_pkg::stat_t     stat,
    output ffha_pkg::out_t      res
);

    localparam int WORDS = HEAP_CAPACITY_BYTES / 4;
    localparam int AW    = $clog2(WORDS);
    localparam int PW    = $clog2(HEAP_CAPACITY_BYTES) + 1;
    localparam logic [31:0]   CAP32    = 32'(HEAP_CAPACITY_BYTES);
    localparam logic [31:0]   WORDS32  = 32'(WORDS);
    localparam logic [PW-1:0] CLR_LAST = PW'(HEAP_CAPACITY_BYTES - 4);

    logic [PW-1:0] p_reg, p_next;
    logic [PW-1:0] h_reg, h_next;
    logic [PW-1:0] prev_reg, prev_next;
    logic [PW-1:0] b_reg, b_next;
    logic [PW-1:0] end_reg, end_next;
    logic [PW-1:0] active_reg, active_next;
    logic [31:0]   sig_reg, sig_next;
    logic [31:0]   sz_reg, sz_next;
    logic [31:0]   hsz_reg, hsz_next;
    logic [31:0]   used_reg, used_next;
    logic [15:0]   req_reg, req_next;
    logic [11:0]   off_reg, off_next;
    logic [11:0]   pay_reg, pay_next;
    logic          have_prev_reg, have_prev_next;
    logic [12:0]   heap_bytes_reg, heap_bytes_next;
    logic          rd_oor_reg, rd_oor_next;
    ffha_pkg::out_t res_reg, res_next;

    logic [31:0] ram_q, rdata, p32, np32, req32;
    logic [32:0] nx33, end33;
    logic [15:0] sig_masked;
    logic [31:0] hb32, clamp1, clamp2, clamp3;
    logic [31:0] ra, wa, wd;
    logic        we;

    assign rdata = rd_oor_reg ? 32'd0 : ram_q;
    assign p32   = 32'(p_reg);
    assign req32 = 32'(req_reg);
    assign nx33  = {1'b0, p32} + 33'd8 + {1'b0, sz_reg};
    assign end33 = (nx33 > 33'(active_reg)) ? 33'(active_reg) : nx33;
    assign np32  = p32 + 32'd8 + req32;
    assign sig_masked = sig_reg[15:0] & ~ffha_pkg::SIG_LOW_MASK;

    assign hb32   = 32'(cmd.fmt_boot ? ffha_pkg::HEAP_BYTES_DEFAULT : heap_bytes_reg);
    assign clamp1 = (hb32 < 32'd16) ? 32'd16 : hb32;
    assign clamp2 = (clamp1 > CAP32) ? CAP32 : clamp1;
    assign clamp3 = clamp2 & ~32'd3;

    always_comb
    begin
        stat.sig_ok    = (sig_masked == ffha_pkg::SIG_FREE[15:0])
                      || (sig_masked == ffha_pkg::SIG_BLOCK)
                      || (sig_masked == ffha_pkg::SIG_DATA)
                      || (sig_masked == ffha_pkg::SIG_HEAP);
        stat.sig_free  = (sig_reg == ffha_pkg::SIG_FREE);
        stat.fits      = (sz_reg >= req32);
        stat.nx_ok     = (nx33 < 33'(active_reg));
        stat.zero_more = (b_reg < end_reg);
        stat.split_ok  = ((sz_reg - req32) >= 32'd12);
        stat.p_lt_h    = (p_reg < h_reg);
        stat.have_prev = have_prev_reg;
        stat.rel_bad   = (off_reg < 12'd8) || (off_reg[1:0] != 2'd0)
                      || (32'(off_reg) > 32'(active_reg));
        stat.clr_last  = (b_reg == CLR_LAST);
    end

    always_comb
    begin
        ra = p32;
        wa = 32'd0;
        wd = 32'd0;
        we = 1'b0;
        case (cmd.op)
            ffha_pkg::OP_RD_P4:
            begin
                ra = p32 + 32'd4;
            end
            ffha_pkg::OP_CLR, ffha_pkg::OP_ZERO:
            begin
                wa = 32'(b_reg);
                we = 1'b1;
            end
            ffha_pkg::OP_FMT0:
            begin
                wd = ffha_pkg::SIG_FREE;
                we = 1'b1;
            end
            ffha_pkg::OP_FMT1:
            begin
                wa = 32'd4;
                wd = 32'(active_reg) - 32'd8;
                we = 1'b1;
            end
            ffha_pkg::OP_MARK:
            begin
                wa = p32;
                wd = 32'(ffha_pkg::SIG_DATA);
                we = 1'b1;
            end
            ffha_pkg::OP_SPLIT_SZ:
            begin
                wa = p32 + 32'd4;
                wd = req32;
                we = 1'b1;
            end
            ffha_pkg::OP_SPLIT_SIG:
            begin
                wa = np32;
                wd = ffha_pkg::SIG_FREE;
                we = 1'b1;
            end
            ffha_pkg::OP_SPLIT_REST:
            begin
                wa = np32 + 32'd4;
                wd = sz_reg - req32 - 32'd8;
                we = 1'b1;
            end
            ffha_pkg::OP_REL_FREE:
            begin
                wa = p32;
                wd = ffha_pkg::SIG_FREE;
                we = 1'b1;
            end
            ffha_pkg::OP_MERGE_NEXT:
            begin
                wa = 32'(h_reg) + 32'd4;
                wd = hsz_reg + sz_reg + 32'd8;
                we = 1'b1;
            end
            ffha_pkg::OP_MERGE_PREV:
            begin
                wa = p32 + 32'd4;
                wd = sz_reg + hsz_reg + 32'd8;
                we = 1'b1;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    assign rd_oor_next = ((ra >> 2) >= WORDS32);

    ffha_ram #(
        .WIDTH(32),
        .DEPTH(WORDS)
    ) u_store (
        .clk   (clk),
        .we    (we && ((wa >> 2) < WORDS32)),
        .waddr (wa[AW+1:2]),
        .wdata (wd),
        .raddr (ra[AW+1:2]),
        .rdata (ram_q)
    );

    always_comb
    begin
        p_next          = p_reg;
        h_next          = h_reg;
        prev_next       = prev_reg;
        b_next          = b_reg;
        end_next        = end_reg;
        active_next     = active_reg;
        sig_next        = sig_reg;
        sz_next         = sz_reg;
        hsz_next        = hsz_reg;
        used_next       = used_reg;
        req_next        = req_reg;
        off_next        = off_reg;
        pay_next        = pay_reg;
        have_prev_next  = have_prev_reg;
        heap_bytes_next = cfg_we ? cfg_wdata : heap_bytes_reg;
        res_next        = res_reg;
        case (cmd.op)
            ffha_pkg::OP_LOAD:
            begin
                req_next = (in_data.request_size + 16'd3) & 16'hFFFC;
                off_next = in_data.release_offset;
                pay_next = 12'd0;
                p_next   = '0;
            end
            ffha_pkg::OP_RD_P4:
            begin
                sig_next = rdata;
            end
            ffha_pkg::OP_LATCH_SZ:
            begin
                sz_next = rdata;
            end
            ffha_pkg::OP_NEXT:
            begin
                p_next = PW'(nx33);
            end
            ffha_pkg::OP_MARK:
            begin
                b_next   = PW'(p32 + 32'd8);
                end_next = PW'(end33);
            end
            ffha_pkg::OP_ZERO, ffha_pkg::OP_CLR:
            begin
                b_next = b_reg + PW'(4);
            end
            ffha_pkg::OP_SPLIT_REST:
            begin
                used_next = used_reg + 32'd8;
                sz_next   = req32;
            end
            ffha_pkg::OP_ALLOC_DONE:
            begin
                used_next = used_reg + sz_reg;
                pay_next  = 12'(p32 + 32'd8);
            end
            ffha_pkg::OP_REL_INIT:
            begin
                p_next = PW'(off_reg) - PW'(8);
            end
            ffha_pkg::OP_REL_FREE:
            begin
                used_next = used_reg - sz_reg;
                h_next    = p_reg;
                hsz_next  = sz_reg;
                if (stat.nx_ok)
                begin
                    p_next = PW'(nx33);
                end
            end
            ffha_pkg::OP_MERGE_NEXT:
            begin
                hsz_next  = hsz_reg + sz_reg + 32'd8;
                used_next = used_reg - 32'd8;
            end
            ffha_pkg::OP_BW_INIT:
            begin
                p_next         = '0;
                have_prev_next = 1'b0;
            end
            ffha_pkg::OP_BW_ADV:
            begin
                prev_next      = p_reg;
                have_prev_next = 1'b1;
                if (stat.nx_ok)
                begin
                    p_next = PW'(nx33);
                end
            end
            ffha_pkg::OP_P_PREV:
            begin
                p_next = prev_reg;
            end
            ffha_pkg::OP_MERGE_PREV:
            begin
                used_next = used_reg - 32'd8;
            end
            ffha_pkg::OP_FMT0:
            begin
                active_next = PW'(clamp3);
                used_next   = 32'd8;
            end
            ffha_pkg::OP_FINISH:
            begin
                res_next.status         = cmd.code;
                res_next.payload_offset = pay_reg;
                res_next.used_bytes     = used_reg;
            end
            default:
            begin
                p_next = p_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_reg          <= '0;
            heap_bytes_reg <= ffha_pkg::HEAP_BYTES_DEFAULT;
        end
        else
        begin
            b_reg          <= b_next;
            heap_bytes_reg <= heap_bytes_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg         <= p_next;
        h_reg         <= h_next;
        prev_reg      <= prev_next;
        end_reg       <= end_next;
        active_reg    <= active_next;
        sig_reg       <= sig_next;
        sz_reg        <= sz_next;
        hsz_reg       <= hsz_next;
        used_reg      <= used_next;
        req_reg       <= req_next;
        off_reg       <= off_next;
        pay_reg       <= pay_next;
        have_prev_reg <= have_prev_next;
        rd_oor_reg    <= rd_oor_next;
        res_reg       <= res_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ffha_ctrl.sv -----
// Controller: sequences walks, zeroing, splits and merges over the datapath.
`default_nettype none

module ffha_ctrl (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] func,
    output logic            out_valid,
    input  wire logic       out_stall,
    input  ffha_pkg::stat_t stat,
    output ffha_pkg::cmd_t  cmd
);

    typedef enum logic [21:0] {
        S_CLEAR    = 22'h000001,
        S_FMT0     = 22'h000002,
        S_FMT1     = 22'h000004,
        S_IDLE     = 22'h000008,
        S_DISPATCH = 22'h000010,
        S_RD_SIG   = 22'h000020,
        S_RD_SZ    = 22'h000040,
        S_LAT_SZ   = 22'h000080,
        S_EVAL     = 22'h000100,
        S_A_ZERO   = 22'h000200,
        S_A_SPLIT0 = 22'h000400,
        S_A_SPLIT1 = 22'h000800,
        S_A_SPLIT2 = 22'h001000,
        S_A_DONE   = 22'h002000,
        S_R_FREE   = 22'h004000,
        S_R_MNEXT  = 22'h008000,
        S_BW_INIT  = 22'h010000,
        S_BW_TEST  = 22'h020000,
        S_BW_RD    = 22'h040000,
        S_BW_ADV   = 22'h080000,
        S_BW_END   = 22'h100000,
        S_FINISH   = 22'h200000
    } state_t;

    typedef enum logic [4:0] {
        M_ALLOC    = 5'b00001,
        M_CHECK    = 5'b00010,
        M_REL_HDR  = 5'b00100,
        M_REL_NEXT = 5'b01000,
        M_REL_PREV = 5'b10000
    } mode_t;

    state_t     state_reg, state_next;
    mode_t      mode_reg, mode_next;
    logic [1:0] func_reg, func_next;
    logic [1:0] code_reg, code_next;
    logic       boot_reg, boot_next;
    logic       out_valid_reg, out_valid_next;
    logic       bw_lat_reg, bw_lat_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        func_next      = func_reg;
        code_next      = code_reg;
        boot_next      = boot_reg;
        bw_lat_next    = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        cmd.op         = ffha_pkg::OP_IDLE;
        cmd.code       = code_reg;
        cmd.fmt_boot   = boot_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.op = ffha_pkg::OP_CLR;
                if (stat.clr_last)
                begin
                    state_next = S_FMT0;
                end
            end
            S_FMT0:
            begin
                cmd.op     = ffha_pkg::OP_FMT0;
                state_next = S_FMT1;
            end
            S_FMT1:
            begin
                cmd.op     = ffha_pkg::OP_FMT1;
                boot_next  = 1'b0;
                code_next  = ffha_pkg::ST_OK;
                state_next = boot_reg ? S_IDLE : S_FINISH;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = ffha_pkg::OP_LOAD;
                    func_next  = func;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (func_reg)
                    ffha_pkg::FUNC_ALLOC:
                    begin
                        mode_next  = M_ALLOC;
                        state_next = S_RD_SIG;
                    end
                    ffha_pkg::FUNC_CHECK:
                    begin
                        mode_next  = M_CHECK;
                        state_next = S_RD_SIG;
                    end
                    ffha_pkg::FUNC_RELEASE:
                    begin
                        if (stat.rel_bad)
                        begin
                            code_next  = ffha_pkg::ST_INVALID;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cmd.op     = ffha_pkg::OP_REL_INIT;
                            mode_next  = M_REL_HDR;
                            state_next = S_RD_SIG;
                        end
                    end
                    default:
                    begin
                        state_next = S_FMT0;
                    end
                endcase
            end
            S_RD_SIG:
            begin
                cmd.op     = ffha_pkg::OP_RD_P;
                state_next = S_RD_SZ;
            end
            S_RD_SZ:
            begin
                cmd.op     = ffha_pkg::OP_RD_P4;
                state_next = S_LAT_SZ;
            end
            S_LAT_SZ:
            begin
                cmd.op     = ffha_pkg::OP_LATCH_SZ;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                case (mode_reg)
                    M_ALLOC:
                    begin
                        if (!stat.sig_ok)
                        begin
                            code_next  = ffha_pkg::ST_CORRUPT;
                            state_next = S_FINISH;
                        end
                        else if (stat.sig_free && stat.fits)
                        begin
                            cmd.op     = ffha_pkg::OP_MARK;
                            state_next = S_A_ZERO;
                        end
                        else if (stat.nx_ok)
                        begin
                            cmd.op     = ffha_pkg::OP_NEXT;
                            state_next = S_RD_SIG;
                        end
                        else
                        begin
                            code_next  = ffha_pkg::ST_NOMEM;
                            state_next = S_FINISH;
                        end
                    end
                    M_CHECK:
                    begin
                        if (!stat.sig_ok)
                        begin
                            code_next  = ffha_pkg::ST_CORRUPT;
                            state_next = S_FINISH;
                        end
                        else if (stat.nx_ok)
                        begin
                            cmd.op     = ffha_pkg::OP_NEXT;
                            state_next = S_RD_SIG;
                        end
                        else
                        begin
                            code_next  = ffha_pkg::ST_OK;
                            state_next = S_FINISH;
                        end
                    end
                    M_REL_HDR:
                    begin
                        if (!stat.sig_ok)
                        begin
                            code_next  = ffha_pkg::ST_CORRUPT;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_R_FREE;
                        end
                    end
                    M_REL_NEXT:
                    begin
                        state_next = stat.sig_free ? S_R_MNEXT : S_BW_INIT;
                    end
                    default:
                    begin
                        if (stat.sig_free)
                        begin
                            cmd.op = ffha_pkg::OP_MERGE_PREV;
                        end
                        code_next  = ffha_pkg::ST_OK;
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_A_ZERO:
            begin
                if (stat.zero_more)
                begin
                    cmd.op = ffha_pkg::OP_ZERO;
                end
                else
                begin
                    state_next = stat.split_ok ? S_A_SPLIT0 : S_A_DONE;
                end
            end
            S_A_SPLIT0:
            begin
                cmd.op     = ffha_pkg::OP_SPLIT_SZ;
                state_next = S_A_SPLIT1;
            end
            S_A_SPLIT1:
            begin
                cmd.op     = ffha_pkg::OP_SPLIT_SIG;
                state_next = S_A_SPLIT2;
            end
            S_A_SPLIT2:
            begin
                cmd.op     = ffha_pkg::OP_SPLIT_REST;
                state_next = S_A_DONE;
            end
            S_A_DONE:
            begin
                cmd.op     = ffha_pkg::OP_ALLOC_DONE;
                code_next  = ffha_pkg::ST_OK;
                state_next = S_FINISH;
            end
            S_R_FREE:
            begin
                cmd.op = ffha_pkg::OP_REL_FREE;
                if (stat.nx_ok)
                begin
                    mode_next  = M_REL_NEXT;
                    state_next = S_RD_SIG;
                end
                else
                begin
                    state_next = S_BW_INIT;
                end
            end
            S_R_MNEXT:
            begin
                cmd.op     = ffha_pkg::OP_MERGE_NEXT;
                state_next = S_BW_INIT;
            end
            S_BW_INIT:
            begin
                cmd.op     = ffha_pkg::OP_BW_INIT;
                state_next = S_BW_TEST;
            end
            S_BW_TEST:
            begin
                if (stat.p_lt_h)
                begin
                    state_next = S_BW_RD;
                end
                else if (stat.have_prev)
                begin
                    state_next = S_BW_END;
                end
                else
                begin
                    code_next  = ffha_pkg::ST_OK;
                    state_next = S_FINISH;
                end
            end
            S_BW_RD:
            begin
                cmd.op      = ffha_pkg::OP_RD_P4;
                bw_lat_next = 1'b1;
                state_next  = S_BW_ADV;
            end
            S_BW_ADV:
            begin
                if (bw_lat_reg)
                begin
                    cmd.op = ffha_pkg::OP_LATCH_SZ;
                end
                else
                begin
                    cmd.op     = ffha_pkg::OP_BW_ADV;
                    state_next = stat.nx_ok ? S_BW_TEST : S_BW_END;
                end
            end
            S_BW_END:
            begin
                cmd.op     = ffha_pkg::OP_P_PREV;
                mode_next  = M_REL_PREV;
                state_next = S_RD_SIG;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op         = ffha_pkg::OP_FINISH;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            mode_reg      <= M_ALLOC;
            func_reg      <= ffha_pkg::FUNC_ALLOC;
            code_reg      <= ffha_pkg::ST_OK;
            boot_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
            bw_lat_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            func_reg      <= func_next;
            code_reg      <= code_next;
            boot_reg      <= boot_next;
            out_valid_reg <= out_valid_next;
            bw_lat_reg    <= bw_lat_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("controller state not one-hot");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_DISPATCH))
        else $error("accepted request did not dispatch");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && out_valid_reg && out_stall) |=> (state_reg == S_FINISH))
        else $error("result overwritten while held");

    assert property (@(posedge clk) disable iff (!rst_n)
        boot_reg |-> (state_reg == S_CLEAR || state_reg == S_FMT0 || state_reg == S_FMT1))
        else $error("request path entered before boot format");

endmodule

`default_nettype wire

// ----- rtl/core/first_fit_heap_allocator_top.sv -----
// Top level of the first-fit heap allocator.
//
//  port group   dir  handshake          contents
//  in_*         in   in_valid/in_stall   func, request_size, release_offset
//  out_*        out  out_valid/out_stall status, payload_offset, used_bytes
//  cfg_*        in   cfg_we              heap_bytes
//
//  One request at a time; every word access goes through the one store RAM.
//  A check walks the blocks; a format writes the first header.
//  Allocate walks blocks, zeroes each payload word, then may split the block.
//  Release frees the header, merges a free next block, walks the blocks before it,
//  then tests the block before and finishes; an invalid offset is rejected without a walk.
//  After reset a clearing pass writes every store word, with in_stall high.
`default_nettype none

module first_fit_heap_allocator_top #(
    parameter int HEAP_CAPACITY_BYTES = ffha_pkg::HEAP_CAPACITY_BYTES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  ffha_pkg::in_t    in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output ffha_pkg::out_t   out_data,
    input  wire logic        cfg_we,
    input  wire logic [12:0] cfg_wdata
);

    ffha_pkg::cmd_t  cmd;
    ffha_pkg::stat_t stat;

    ffha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (in_data.func),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    ffha_dp #(
        .HEAP_CAPACITY_BYTES(HEAP_CAPACITY_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .res       (out_data)
    );

endmodule

`default_nettype wire

// ----- sim/heap_result_checker.sv -----
// Checker for the heap allocator: predicts each result and compares it with the block.
module heap_result_checker
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_stall,
    input  ffha_pkg::in_t  in_data,
    input  logic           out_valid,
    input  logic           out_stall,
    input  ffha_pkg::out_t out_data,
    input  logic           cfg_we,
    input  logic [12:0]    cfg_wdata,
    output int             fails,
    output int             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORDS = ffha_pkg::HEAP_CAPACITY_BYTES / 4;

    logic [31:0]    heap_words [WORDS];
    logic [31:0]    used_total;
    logic [31:0]    heap_bytes_reg;
    logic [31:0]    active_bytes;
    ffha_pkg::out_t result_q [$];

    function automatic logic [31:0] word_at(logic [31:0] b);
        logic [31:0] w;
        w = b >> 2;
        return (w < WORDS) ? heap_words[w] : 32'd0;
    endfunction

    task automatic word_put(logic [31:0] b, logic [31:0] v);
        logic [31:0] w;
        w = b >> 2;
        if (w < WORDS)
        begin
            heap_words[w] = v;
        end
    endtask

    function automatic bit sig_good(logic [31:0] s);
        logic [15:0] m;
        m = s[15:0] & ~ffha_pkg::SIG_LOW_MASK;
        return m == ffha_pkg::SIG_FREE[15:0] || m == ffha_pkg::SIG_BLOCK
            || m == ffha_pkg::SIG_DATA || m == ffha_pkg::SIG_HEAP;
    endfunction

    function automatic bit step_block(logic [31:0] p, output logic [31:0] nx);
        longint unsigned n;
        n = longint'(p) + 8 + longint'(word_at(p + 4));
        nx = n[31:0];
        return n < longint'(active_bytes);
    endfunction

    task automatic format_heap();
        logic [31:0] sz;
        sz = heap_bytes_reg;
        if (sz < 16)
        begin
            sz = 16;
        end
        if (sz > ffha_pkg::HEAP_CAPACITY_BYTES)
        begin
            sz = ffha_pkg::HEAP_CAPACITY_BYTES;
        end
        sz = sz & ~32'd3;
        active_bytes = sz;
        word_put(0, ffha_pkg::SIG_FREE);
        word_put(4, sz - 8);
        used_total = 8;
    endtask

    task automatic allocate(logic [15:0] req_in, output logic [1:0] st,
                            output logic [31:0] pay);
        logic [31:0] req, p, sig, sz, nx;
        longint unsigned stop, b;
        bit done;
        req = ((32'(req_in) + 3) & 32'hFFFF) & ~32'd3;
        p = 0;
        pay = 0;
        done = 0;
        while (!done)
        begin
            sig = word_at(p);
            sz = word_at(p + 4);
            if (!sig_good(sig))
            begin
                st = ffha_pkg::ST_CORRUPT;
                done = 1;
            end
            else if (sig == ffha_pkg::SIG_FREE && sz >= req)
            begin
                stop = longint'(p) + 8 + longint'(sz);
                if (stop > longint'(active_bytes))
                begin
                    stop = active_bytes;
                end
                word_put(p, 32'(ffha_pkg::SIG_DATA));
                for (b = longint'(p) + 8; b < stop; b += 4)
                begin
                    word_put(b[31:0], 0);
                end
                if (sz - req >= 12)
                begin
                    word_put(p + 4, req);
                    word_put(p + 8 + req, ffha_pkg::SIG_FREE);
                    word_put(p + 12 + req, sz - req - 8);
                    used_total += 8;
                    sz = req;
                end
                used_total += sz;
                pay = p + 8;
                st = ffha_pkg::ST_OK;
                done = 1;
            end
            else if (!step_block(p, nx))
            begin
                st = ffha_pkg::ST_NOMEM;
                done = 1;
            end
            else
            begin
                p = nx;
            end
        end
    endtask

    task automatic release_block(logic [31:0] off, output logic [1:0] st);
        logic [31:0] h, nx, s, prev;
        bit have_prev;
        prev = 0;
        have_prev = 0;
        if (off < 8 || off[1:0] != 0 || off > active_bytes)
        begin
            st = ffha_pkg::ST_INVALID;
        end
        else if (!sig_good(word_at(off - 8)))
        begin
            st = ffha_pkg::ST_CORRUPT;
        end
        else
        begin
            h = off - 8;
            word_put(h, ffha_pkg::SIG_FREE);
            used_total -= word_at(h + 4);
            if (step_block(h, nx) && word_at(nx) == ffha_pkg::SIG_FREE)
            begin
                word_put(h + 4, word_at(h + 4) + word_at(nx + 4) + 8);
                used_total -= 8;
            end
            s = 0;
            while (s < h)
            begin
                prev = s;
                have_prev = 1;
                if (!step_block(prev, s))
                begin
                    break;
                end
            end
            if (have_prev && word_at(prev) == ffha_pkg::SIG_FREE)
            begin
                word_put(prev + 4, word_at(prev + 4) + word_at(h + 4) + 8);
                used_total -= 8;
            end
            st = ffha_pkg::ST_OK;
        end
    endtask

    function automatic logic [1:0] check_heap();
        logic [31:0] p;
        p = 0;
        forever
        begin
            if (!sig_good(word_at(p)))
            begin
                return ffha_pkg::ST_CORRUPT;
            end
            if (!step_block(p, p))
            begin
                return ffha_pkg::ST_OK;
            end
        end
    endfunction

    task automatic predict_result(ffha_pkg::in_t req, output ffha_pkg::out_t r);
        logic [1:0]  st;
        logic [31:0] pay;
        st = ffha_pkg::ST_OK;
        pay = 0;
        case (req.func)
            ffha_pkg::FUNC_ALLOC:
            begin
                allocate(req.request_size, st, pay);
            end
            ffha_pkg::FUNC_RELEASE:
            begin
                release_block(32'(req.release_offset), st);
            end
            ffha_pkg::FUNC_CHECK:
            begin
                st = check_heap();
            end
            default:
            begin
                format_heap();
            end
        endcase
        r.status = st;
        r.payload_offset = (st == ffha_pkg::ST_OK) ? pay[11:0] : 12'd0;
        r.used_bytes = used_total;
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("checker: %s mismatch, got %0h expected %0h", what, got, want);
        fails++;
    endtask

    assign pending = result_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        ffha_pkg::out_t r;
        if (!rst_n)
        begin
            for (int i = 0; i < WORDS; i++)
            begin
                heap_words[i] = 0;
            end
            heap_bytes_reg = 32'(ffha_pkg::HEAP_BYTES_DEFAULT);
            format_heap();
            result_q.delete();
            fails = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                begin
                    report("unexpected result", 32'(out_data), 0);
                end
                else
                begin
                    r = result_q.pop_front();
                    if (out_data.status != r.status)
                    begin
                        report("status", 32'(out_data.status), 32'(r.status));
                    end
                    if (out_data.payload_offset != r.payload_offset)
                    begin
                        report("payload_offset", 32'(out_data.payload_offset),
                               32'(r.payload_offset));
                    end
                    if (out_data.used_bytes != r.used_bytes)
                    begin
                        report("used_bytes", out_data.used_bytes, r.used_bytes);
                    end
                end
            end
            if (cfg_we)
            begin
                heap_bytes_reg = 32'(cfg_wdata);
            end
            if (in_valid && !in_stall)
            begin
                predict_result(in_data, r);
                result_q.push_back(r);
            end
        end
    end
endmodule

// ----- sim/tb.sv -----
// Testbench top for the heap allocator: stimulus, receiver stalls and the verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 5_000_000;

    logic           clk = 0;
    logic           rst_n = 0;
    logic           in_valid = 0;
    logic           in_stall;
    ffha_pkg::in_t  in_data = '0;
    logic           out_valid;
    logic           out_stall = 0;
    ffha_pkg::out_t out_data;
    logic           cfg_we = 0;
    logic [12:0]    cfg_wdata = '0;
    int             fails;
    int             pending;
    int             cycles = 0;
    bit             no_idle = 0;
    logic [11:0]    live_offsets [$];

    first_fit_heap_allocator_top u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    heap_result_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .fails(fails), .pending(pending)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // hold stall for a drawn number of cycles after each accepted result
    initial
    begin
        int n;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (out_data.payload_offset != 0)
                begin
                    live_offsets.push_back(out_data.payload_offset);
                end
                n = no_idle ? 0 : $urandom_range(0, 14);
                if (n > 0)
                begin
                    out_stall <= 1;
                    repeat (n) @(posedge clk);
                    out_stall <= 0;
                end
            end
        end
    end

    task automatic send_request(logic [1:0] f, logic [15:0] sz, logic [11:0] off);
        int gap;
        ffha_pkg::in_t req;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        req.func = f;
        req.request_size = sz;
        req.release_offset = off;
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        in_data <= req;
        if (f == ffha_pkg::FUNC_FORMAT)
        begin
            live_offsets.delete();
        end
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic send_random();
        int r, k;
        logic [15:0] sz;
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            k = $urandom_range(0, 19);
            if (k == 0)
            begin
                sz = 16'($urandom);
            end
            else if (k < 3)
            begin
                sz = 16'($urandom_range(200, 1200));
            end
            else
            begin
                sz = 16'($urandom_range(0, 96));
            end
            send_request(ffha_pkg::FUNC_ALLOC, sz, 12'($urandom));
        end
        else if (r < 80 && live_offsets.size() != 0)
        begin
            k = $urandom_range(0, live_offsets.size() - 1);
            send_request(ffha_pkg::FUNC_RELEASE, 16'($urandom), live_offsets[k]);
            live_offsets.delete(k);
        end
        else if (r < 88)
        begin
            send_request(ffha_pkg::FUNC_RELEASE, 16'($urandom), 12'($urandom));
        end
        else if (r < 97)
        begin
            send_request(ffha_pkg::FUNC_CHECK, 16'($urandom), 12'($urandom));
        end
        else
        begin
            send_request(ffha_pkg::FUNC_FORMAT, 16'($urandom), 12'($urandom));
        end
    endtask

    initial
    begin
        logic [12:0] settings [8];
        settings = '{13'd16, 13'd8191, 13'd0, 13'd100, 13'd517, 13'd2048,
                     13'd4096, 13'd4096};
        repeat (3) @(posedge clk);
        rst_n <= 1;

        send_request(ffha_pkg::FUNC_CHECK, 16'h0, 12'h0);
        send_request(ffha_pkg::FUNC_ALLOC, 16'd0, 12'h0);
        send_request(ffha_pkg::FUNC_ALLOC, 16'd1, 12'h0);
        send_request(ffha_pkg::FUNC_ALLOC, 16'hFFFF, 12'h0);
        send_request(ffha_pkg::FUNC_ALLOC, 16'hFFFC, 12'h0);
        send_request(ffha_pkg::FUNC_ALLOC, 16'd4096, 12'h0);
        send_request(ffha_pkg::FUNC_ALLOC, 16'd12, 12'h0);
        send_request(ffha_pkg::FUNC_RELEASE, 16'h0, 12'd8);
        send_request(ffha_pkg::FUNC_RELEASE, 16'h0, 12'd8);
        send_request(ffha_pkg::FUNC_RELEASE, 16'h0, 12'd0);
        send_request(ffha_pkg::FUNC_RELEASE, 16'h0, 12'd6);
        send_request(ffha_pkg::FUNC_RELEASE, 16'h0, 12'hFFF);
        send_request(ffha_pkg::FUNC_RELEASE, 16'h0, 12'd2000);
        send_request(ffha_pkg::FUNC_RELEASE, 16'h0, 12'd24);
        send_request(ffha_pkg::FUNC_CHECK, 16'h0, 12'h0);
        send_request(ffha_pkg::FUNC_FORMAT, 16'h0, 12'h0);
        send_request(ffha_pkg::FUNC_ALLOC, 16'd4088, 12'h0);
        send_request(ffha_pkg::FUNC_ALLOC, 16'd4, 12'h0);
        send_request(ffha_pkg::FUNC_RELEASE, 16'h0, 12'd8);
        send_request(ffha_pkg::FUNC_CHECK, 16'h0, 12'h0);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            no_idle = (ph == 7);
            cfg_we <= 1;
            cfg_wdata <= (ph == 5) ? 13'($urandom_range(16, 4096)) : settings[ph];
            @(posedge clk);
            cfg_we <= 0;
            send_request(ffha_pkg::FUNC_FORMAT, 16'h0, 12'h0);
            for (int i = 0; i < 34; i++)
            begin
                send_random();
            end
            send_request(ffha_pkg::FUNC_RELEASE, 16'h0, 12'hFFC);
            drain();
        end

        if (fails == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
